[rtl/core/wavf_pkg.sv]
`default_nettype none

package wavf_pkg;

  localparam int SCORE_W = 8;
  localparam int LIK_W   = 16;
  localparam int VEL_W   = 12;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 12;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 1;

  localparam logic [GAIN_W-1:0]  GAIN_ONE    = 16'd32768;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd27853;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 12'd4000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd400;

  localparam logic [IDX_W-1:0] REG_SMOOTHING_GAIN = 1'd0;
  localparam logic [IDX_W-1:0] REG_SPEED_LIMIT    = 1'd1;

endpackage

`default_nettype wire

[rtl/core/wavf_window.sv]
`default_nettype none

module wavf_window #(
  parameter int DEPTH = 5,
  parameter int SUM_W = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic [wavf_pkg::SCORE_W-1:0] score,
  output logic      [SUM_W-1:0]            sum,
  output logic                             sum_valid
);
  import wavf_pkg::*;

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [SCORE_W-1:0] store [DEPTH];
  logic [SCORE_W-1:0] evict;
  logic [SCORE_W-1:0] score_q;
  logic [SLOT_W-1:0]  newest;
  logic [SLOT_W-1:0]  slot_next;
  logic [FILL_W-1:0]  fill;
  logic               full;
  logic               pend;

  assign slot_next = (newest == SLOT_W'(DEPTH - 1)) ? '0 : newest + 1'b1;
  assign full      = (fill == FILL_W'(DEPTH));

  // The slot being overwritten holds the oldest score once the ring is full.
  always_ff @(posedge clk) begin
    if (push) begin
      store[slot_next] <= score;
      evict            <= full ? store[slot_next] : '0;
      score_q          <= score;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest    <= SLOT_W'(DEPTH - 1);
      fill      <= '0;
      sum       <= '0;
      pend      <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      pend      <= push;
      sum_valid <= pend;
      if (push) begin
        newest <= slot_next;
        if (!full) begin
          fill <= fill + 1'b1;
        end
      end
      if (pend) begin
        sum <= sum - SUM_W'(evict) + SUM_W'(score_q);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/wavf_norm.sv]
`default_nettype none

module wavf_norm #(
  parameter int SUM_W   = 12,
  parameter int DIVISOR = 1275
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [SUM_W-1:0]           sum,
  output logic      [wavf_pkg::LIK_W-1:0] likelihood,
  output logic                            done
);
  import wavf_pkg::*;

  localparam int REM_W = SUM_W + 1;
  localparam int CNT_W = $clog2(LIK_W + 1);

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem2;
  logic [LIK_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             sat;
  logic             ge;

  // Restoring division, one quotient bit per cycle, most significant first.
  assign rem2       = {rem[SUM_W-1:0], 1'b0};
  assign ge         = (rem2 >= REM_W'(DIVISOR));
  assign likelihood = sat ? '1 : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (start) begin
        rem  <= {1'b0, sum};
        sat  <= (sum >= SUM_W'(DIVISOR));
        cnt  <= CNT_W'(LIK_W);
        done <= 1'b0;
      end else if (cnt != '0) begin
        rem  <= ge ? rem2 - REM_W'(DIVISOR) : rem2;
        quo  <= {quo[LIK_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/wavf_blend.sv]
`default_nettype none

module wavf_blend (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [wavf_pkg::LIK_W-1:0]   likelihood,
  input  wire logic [wavf_pkg::GAIN_W-1:0]  gain,
  input  wire logic [wavf_pkg::LIMIT_W-1:0] limit,
  output logic      [wavf_pkg::VEL_W-1:0]   velocity,
  output logic                              done
);
  import wavf_pkg::*;

  localparam int ACC_W = 29;
  localparam int CMP_W = LIK_W + 1;
  localparam int CNT_W = $clog2(VEL_W + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TARGET,
    PH_MIX,
    PH_FINISH
  } phase_t;

  phase_t             phase;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_next;
  logic [ACC_W-1:0]   part;
  logic [CMP_W-1:0]   comp;
  logic [GAIN_W-1:0]  alpha;
  logic [GAIN_W-1:0]  alpha_c;
  logic [LIMIT_W-1:0] vmax_sh;
  logic [VEL_W-1:0]   vp_sh;
  logic [VEL_W-1:0]   tgt_sh;
  logic [CNT_W-1:0]   cnt;
  logic [13:0]        v_raw;

  assign v_raw = acc[28:15];

  // Shift-and-add over the multiplier bits, most significant first.
  always_comb begin
    part = '0;
    case (phase)
      PH_TARGET: begin
        part = vmax_sh[LIMIT_W-1] ? ACC_W'(comp) : '0;
      end
      PH_MIX: begin
        part = (vp_sh[VEL_W-1] ? ACC_W'(alpha_c) : '0)
             + (tgt_sh[VEL_W-1] ? ACC_W'(alpha) : '0);
      end
      default: begin
        part = '0;
      end
    endcase
    acc_next = {acc[ACC_W-2:0], 1'b0} + part;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      velocity <= '0;
      done     <= 1'b0;
      cnt      <= '0;
    end else begin
      done <= (phase == PH_FINISH);
      case (phase)
        PH_IDLE: begin
          if (start) begin
            comp    <= CMP_W'(17'h10000) - CMP_W'(likelihood);
            alpha   <= (gain > GAIN_ONE) ? GAIN_ONE : gain;
            alpha_c <= GAIN_ONE - ((gain > GAIN_ONE) ? GAIN_ONE : gain);
            vmax_sh <= (limit > LIMIT_MAX) ? LIMIT_MAX : limit;
            vp_sh   <= velocity;
            acc     <= '0;
            cnt     <= CNT_W'(LIMIT_W);
            phase   <= PH_TARGET;
          end
        end
        PH_TARGET: begin
          vmax_sh <= {vmax_sh[LIMIT_W-2:0], 1'b0};
          if (cnt == CNT_W'(1)) begin
            tgt_sh <= acc_next[27:16];
            acc    <= '0;
            cnt    <= CNT_W'(VEL_W);
            phase  <= PH_MIX;
          end else begin
            acc <= acc_next;
            cnt <= cnt - 1'b1;
          end
        end
        PH_MIX: begin
          acc    <= acc_next;
          vp_sh  <= {vp_sh[VEL_W-2:0], 1'b0};
          tgt_sh <= {tgt_sh[VEL_W-2:0], 1'b0};
          cnt    <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            phase <= PH_FINISH;
          end
        end
        PH_FINISH: begin
          velocity <= (v_raw > 14'(LIMIT_MAX)) ? LIMIT_MAX : v_raw[VEL_W-1:0];
          phase    <= PH_IDLE;
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/window_average_velocity_filter_core.sv]
// Channel   Direction  Beat contents
// s_axis    in         score (8 bits)
// m_axis    out        likelihood (16 bits), velocity (12 bits)
// wr        in         register write: smoothing_gain, speed_limit
//
// One score is in flight at a time; after the accepting edge it passes the ring
// window, the bit-serial division and the two 12-bit serial multiplies, and the
// result is then loaded into the output register.
// The output register frees the core, so a new score is taken while a result
// beat still waits; a stalled result holds the core only if the next one is done.
// rst is synchronous and returns the window, the velocity history and both
// registers to their reset values.
`default_nettype none

module window_average_velocity_filter_core #(
  parameter int WINDOW_DEPTH = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,  // [7:0] score
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [31:0]                 m_tdata,  // [15:0] likelihood, [27:16] velocity
  input  wire logic                        wr_en,
  input  wire logic [wavf_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [wavf_pkg::CFG_W-1:0]  wr_data
);
  import wavf_pkg::*;

  localparam int DIVISOR = WINDOW_DEPTH * 255;
  localparam int SUM_W   = $clog2(DIVISOR + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WINDOW,
    ST_NORM,
    ST_BLEND,
    ST_HOLD
  } state_t;

  state_t             state;
  logic [GAIN_W-1:0]  gain;
  logic [LIMIT_W-1:0] limit;
  logic [SUM_W-1:0]   sum;
  logic               sum_valid;
  logic [LIK_W-1:0]   likelihood;
  logic               norm_done;
  logic [VEL_W-1:0]   velocity;
  logic               blend_done;
  logic               push;
  logic               norm_start;
  logic               blend_start;
  logic               out_free;
  logic               out_load;
  logic [LIK_W-1:0]   lik_q;
  logic [VEL_W-1:0]   vel_q;

  assign s_tready    = (state == ST_IDLE);
  assign push        = s_tvalid && s_tready;
  assign norm_start  = (state == ST_WINDOW) && sum_valid;
  assign blend_start = (state == ST_NORM) && norm_done;
  assign out_free    = !m_tvalid || m_tready;
  assign out_load    = (((state == ST_BLEND) && blend_done) || (state == ST_HOLD)) && out_free;
  assign m_tdata     = {4'b0, vel_q, lik_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      gain  <= GAIN_RESET;
      limit <= LIMIT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_SMOOTHING_GAIN: gain  <= wr_data[GAIN_W-1:0];
        REG_SPEED_LIMIT:    limit <= wr_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (push) begin
            state <= ST_WINDOW;
          end
        end
        ST_WINDOW: begin
          if (sum_valid) begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (norm_done) begin
            state <= ST_BLEND;
          end
        end
        ST_BLEND, ST_HOLD: begin
          if (out_load) begin
            lik_q <= likelihood;
            vel_q <= velocity;
            state <= ST_IDLE;
          end else if (blend_done) begin
            state <= ST_HOLD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  wavf_window #(
    .DEPTH (WINDOW_DEPTH),
    .SUM_W (SUM_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .score     (s_tdata),
    .sum       (sum),
    .sum_valid (sum_valid)
  );

  wavf_norm #(
    .SUM_W   (SUM_W),
    .DIVISOR (DIVISOR)
  ) u_norm (
    .clk        (clk),
    .rst        (rst),
    .start      (norm_start),
    .sum        (sum),
    .likelihood (likelihood),
    .done       (norm_done)
  );

  wavf_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .start      (blend_start),
    .likelihood (likelihood),
    .gain       (gain),
    .limit      (limit),
    .velocity   (velocity),
    .done       (blend_done)
  );

endmodule

`default_nettype wire

[rtl/core/wavf_checker.sv]
`default_nettype none

module wavf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // One score at a time: the core is busy right after taking a beat.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a score is still in work");

  a_velocity_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[27:16] <= 12'd4000))
    else $error("velocity above the speed ceiling");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:28] == 4'd0))
    else $error("padding bits of the result beat are not zero");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed or dropped");

endmodule

bind window_average_velocity_filter_core wavf_checker u_wavf_checker (.*);

`default_nettype wire

[verif/window_average_velocity_filter_core_tb.sv]
`default_nettype none

module window_average_velocity_filter_core_tb;
  import wavf_pkg::*;

  localparam int DEPTH       = 5;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [VEL_W-1:0] velocity;
    logic [LIK_W-1:0] likelihood;
  } filter_out_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [31:0]        m_tdata;
  logic               wr_en = 1'b0;
  logic [IDX_W-1:0]   wr_index = REG_SMOOTHING_GAIN;
  logic [CFG_W-1:0]   wr_data = '0;

  window_average_velocity_filter_core #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // Local copy of the filter state and registers.
  logic [7:0]         win_scores [DEPTH];
  int unsigned        win_oldest;
  int unsigned        win_newest;
  int unsigned        win_fill;
  logic [11:0]        win_sum;
  logic [VEL_W-1:0]   vel_prev;
  logic [GAIN_W-1:0]  gain_reg;
  logic [LIMIT_W-1:0] limit_reg;

  logic [7:0]   pending_scores [$];
  filter_out_t  predicted_outputs [$];
  int           errors = 0;
  bit           gappy = 1'b0;
  int           hold_requests = 0;

  int           send_gap = 0;
  int           recv_stall = 0;
  int           hold_left = 0;
  int           holds_done = 0;
  int           quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 5);
    return $urandom_range(20, 80);
  endfunction

  task automatic reset_filter_state();
    for (int k = 0; k < DEPTH; k++) win_scores[k] = '0;
    win_oldest = 0;
    win_newest = DEPTH - 1;
    win_fill   = 0;
    win_sum    = '0;
    vel_prev   = '0;
    gain_reg   = GAIN_RESET;
    limit_reg  = LIMIT_RESET;
  endtask

  // Pushes one score into the window and predicts the likelihood and velocity.
  task automatic filter_score(input logic [7:0] score);
    logic [63:0] lik;
    logic [63:0] alpha;
    logic [63:0] vmax;
    logic [63:0] target;
    logic [63:0] v;
    filter_out_t res;
    if (win_fill < DEPTH) begin
      win_fill++;
    end else begin
      win_sum = win_sum - 12'(win_scores[win_oldest]);
      win_oldest = (win_oldest + 1) % DEPTH;
    end
    win_newest = (win_newest + 1) % DEPTH;
    win_scores[win_newest] = score;
    win_sum = win_sum + 12'(score);
    lik = (64'(win_sum) << 16) / 64'(DEPTH * 255);
    if (lik > 64'd65535) lik = 64'd65535;
    alpha  = (gain_reg > GAIN_ONE) ? 64'(GAIN_ONE) : 64'(gain_reg);
    vmax   = (limit_reg > LIMIT_MAX) ? 64'(LIMIT_MAX) : 64'(limit_reg);
    target = ((64'd65536 - lik) * vmax) >> 16;
    v = ((64'(GAIN_ONE) - alpha) * 64'(vel_prev) + alpha * target) >> 15;
    if (v > 64'(LIMIT_MAX)) v = 64'(LIMIT_MAX);
    vel_prev = v[VEL_W-1:0];
    res.likelihood = lik[LIK_W-1:0];
    res.velocity   = v[VEL_W-1:0];
    predicted_outputs.push_back(res);
  endtask

  // Source side: offers queued scores, with random gaps while gappy is set.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) filter_score(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_scores.size() != 0) begin
          s_tdata  <= pending_scores.pop_front();
          s_tvalid <= 1'b1;
          send_gap = gappy ? pick_gap() : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: random back-pressure while gappy is set, long hold-offs on request, and checking.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_outputs.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          filter_out_t exp_out;
          exp_out = predicted_outputs.pop_front();
          if (m_tdata[15:0] !== exp_out.likelihood) begin
            $display("%0t: likelihood mismatch, expected %0d, actual %0d",
                     $time, exp_out.likelihood, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[27:16] !== exp_out.velocity) begin
            $display("%0t: velocity mismatch, expected %0d, actual %0d",
                     $time, exp_out.velocity, m_tdata[27:16]);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (gappy && $urandom_range(0, 2) == 0) recv_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Checks a little after each edge, once the source and sink have updated.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_scores.size() != 0 || s_tvalid || predicted_outputs.size() != 0);
  endtask

  task automatic write_config(input logic [GAIN_W-1:0] gain, input logic [CFG_W-1:0] limit);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_SMOOTHING_GAIN;
    wr_data  <= gain;
    gain_reg = gain;
    @(posedge clk);
    wr_index <= REG_SPEED_LIMIT;
    wr_data  <= limit;
    limit_reg = limit[LIMIT_W-1:0];
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic queue_random_scores(input int count);
    int r;
    logic [7:0] s;
    int n;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        s = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        repeat (DEPTH + 1) pending_scores.push_back(s);
        n += DEPTH + 1;
      end else if (r < 3) begin
        pending_scores.push_back(8'd255);
        n++;
      end else if (r < 5) begin
        pending_scores.push_back(8'd0);
        n++;
      end else begin
        pending_scores.push_back(8'($urandom_range(0, 255)));
        n++;
      end
    end
  endtask

  initial begin
    logic [GAIN_W-1:0] g;
    logic [LIMIT_W-1:0] l;
    reset_filter_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: empty window, filling, full scale, then decay.
    gappy = 1'b1;
    repeat (DEPTH) pending_scores.push_back(8'd0);
    repeat (DEPTH + 1) pending_scores.push_back(8'd255);
    pending_scores.push_back(8'd0);
    pending_scores.push_back(8'd1);
    pending_scores.push_back(8'd128);
    wait_drained();

    // Gain and limit beyond their ranges.
    write_config(16'hFFFF, 16'hFFFF);
    repeat (3) pending_scores.push_back(8'd0);
    repeat (3) pending_scores.push_back(8'd255);
    wait_drained();

    // Zero gain and zero limit.
    write_config(16'd0, 16'd0);
    pending_scores.push_back(8'd254);
    pending_scores.push_back(8'd127);
    pending_scores.push_back(8'd0);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin g = GAIN_ONE; l = LIMIT_MAX; end
        1: begin g = 16'd0; l = LIMIT_MAX; end
        2: begin g = GAIN_ONE - 16'd1; l = 12'd1; end
        3: begin g = 16'd1; l = 12'hFFF; end
        4: begin g = GAIN_RESET; l = LIMIT_RESET; end
        5: begin g = 16'($urandom_range(0, 65535)); l = 12'($urandom_range(0, 4095)); end
        default: begin
          g = 16'($urandom_range(0, 32768));
          l = 12'($urandom_range(0, 4000));
        end
      endcase
      write_config(g, {4'($urandom_range(0, 15)), l});
      gappy = (phase % 3) != 1;
      if (phase == 1) hold_requests++;
      queue_random_scores(104);
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

[window_average_velocity_filter_core.f]
rtl/core/wavf_pkg.sv
rtl/core/wavf_window.sv
rtl/core/wavf_norm.sv
rtl/core/wavf_blend.sv
rtl/core/window_average_velocity_filter_core.sv
rtl/core/wavf_checker.sv
verif/window_average_velocity_filter_core_tb.sv
